// File: hw/rtl/ilbst_pkg.sv
// Shared types and codes for the ICE-lite binding session tracker.
package ilbst_pkg;

   typedef struct packed {
      logic [2:0]  func;
      logic [63:0] tuple_key;
      logic        is_binding;
      logic        has_fingerprint;
      logic [31:0] priority_req;
      logic [1:0]  auth_result;
      logic        old_auth_ok;
      logic        ice_controlled;
      logic        use_candidate;
      logic        has_nomination;
      logic [31:0] nomination;
   } item_type;

   typedef enum logic [3:0] {
      BK_IDLE,
      BK_REQ_CHECK,
      BK_REQ_ROLE,
      BK_REQ_ADD,
      BK_REQ_EVICT,
      BK_REQ_NOM,
      BK_REQ_POST,
      BK_RM_FIND,
      BK_RM_SEL,
      BK_FSEL,
      BK_TICK,
      BK_FLUSH,
      BK_RESTART,
      BK_DRAIN
   } back_state_type;

   localparam logic [2:0] FUNC_REQUEST = 3'd0;
   localparam logic [2:0] FUNC_REMOVE  = 3'd1;
   localparam logic [2:0] FUNC_FSELECT = 3'd2;
   localparam logic [2:0] FUNC_TICK    = 3'd3;
   localparam logic [2:0] FUNC_RESTART = 3'd4;

   localparam logic [1:0] AUTH_OK     = 2'd0;
   localparam logic [1:0] AUTH_UNAUTH = 2'd1;
   localparam logic [1:0] AUTH_BAD    = 2'd2;

   localparam logic [1:0] ICE_NEW  = 2'd0;
   localparam logic [1:0] ICE_CONN = 2'd1;
   localparam logic [1:0] ICE_COMP = 2'd2;
   localparam logic [1:0] ICE_DISC = 2'd3;

   localparam logic [3:0] EV_SUCCESS      = 4'd0;
   localparam logic [3:0] EV_ERR400       = 4'd1;
   localparam logic [3:0] EV_ERR401       = 4'd2;
   localparam logic [3:0] EV_ERR487       = 4'd3;
   localparam logic [3:0] EV_ADDED        = 4'd4;
   localparam logic [3:0] EV_REMOVED      = 4'd5;
   localparam logic [3:0] EV_SELECTED     = 4'd6;
   localparam logic [3:0] EV_CONNECTED    = 4'd7;
   localparam logic [3:0] EV_COMPLETED    = 4'd8;
   localparam logic [3:0] EV_DISCONNECTED = 4'd9;
   localparam logic [3:0] EV_OLD_RETIRED  = 4'd10;

   localparam logic [7:0]  CONSENT_MIN_SEC = 8'd10;
   localparam logic [7:0]  CONSENT_MAX_SEC = 8'd60;
   localparam logic [15:0] MS_PER_SEC      = 16'd1000;

endpackage

// File: hw/rtl/ilbst_front.sv
// Front part: accepts input transfers and holds them in a two-entry queue.
module ilbst_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_stall,
   input  ilbst_pkg::item_type in_item,
   output logic                q_valid,
   output ilbst_pkg::item_type q_item,
   input  logic                q_pop
);
   ilbst_pkg::item_type q_mem_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push, pop;

   always_comb begin
      in_stall  = (count_ff == 2'd2);
      q_valid   = (count_ff != 2'd0);
      q_item    = q_mem_ff[rd_ptr_ff];
      push      = in_valid && !in_stall;
      pop       = q_pop && q_valid;
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_mem_ff[wr_ptr_ff] <= in_item;
      end
   end
endmodule

// File: hw/rtl/ilbst_back.sv
// Back part: session state, tuple table, event sequencer and result register.
module ilbst_back #(
   parameter int MAX_ENTRIES = 8
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                cfg_we,
   input  logic [7:0]          cfg_data,
   input  logic                q_valid,
   input  ilbst_pkg::item_type q_item,
   output logic                q_pop,
   output logic                out_valid,
   input  logic                out_stall,
   output logic [3:0]          out_res,
   output logic [63:0]         out_tuple,
   output logic [1:0]          out_ice_state,
   output logic                out_sel_valid,
   output logic                out_last
);
   localparam int IDX_W    = $clog2(MAX_ENTRIES);
   localparam int EV_DEPTH = MAX_ENTRIES + 6;
   localparam int EV_W     = $clog2(EV_DEPTH);
   localparam int EV_CW    = $clog2(EV_DEPTH + 1);
   localparam logic [IDX_W-1:0] AGE_TOP  = IDX_W'(MAX_ENTRIES - 1);
   localparam logic [IDX_W-1:0] AGE_NEXT = IDX_W'(MAX_ENTRIES - 2);
   localparam logic [IDX_W:0]   FLUSH_END = (IDX_W + 1)'(MAX_ENTRIES);

   ilbst_pkg::back_state_type state_ff, state_in;
   ilbst_pkg::item_type item_ff, item_in;

   logic [1:0]       ist_ff, ist_in;
   logic             sel_ok_ff, sel_ok_in;
   logic [IDX_W-1:0] sel_idx_ff, sel_idx_in;
   logic [31:0]      nom_ff, nom_in;
   logic             old_ff, old_in;
   logic             run_ff, run_in;
   logic [15:0]      rem_ff, rem_in;
   logic [7:0]       cfg_ff;
   logic [IDX_W-1:0] slot_ff, slot_in;
   logic [63:0]      vkey_ff, vkey_in;
   logic [3:0]       post_ff, post_in;
   logic             post_v_ff, post_v_in;
   logic [IDX_W:0]   flush_ff, flush_in;
   logic             valid_ff [MAX_ENTRIES];
   logic             valid_in [MAX_ENTRIES];
   logic [IDX_W-1:0] age_ff [MAX_ENTRIES];
   logic [IDX_W-1:0] age_in [MAX_ENTRIES];
   logic [63:0]      key_ff [MAX_ENTRIES];
   logic             key_we;
   logic [IDX_W-1:0] key_widx;

   logic [3:0]       ev_code_mem [EV_DEPTH];
   logic [63:0]      ev_key_mem [EV_DEPTH];
   logic [EV_CW-1:0] wptr_ff, wptr_in, rptr_ff, rptr_in;
   logic             ev_we;
   logic [3:0]       ev_code;
   logic [63:0]      ev_key;
   logic             ev_load;

   logic             rsp_valid_ff, rsp_valid_in;
   logic [3:0]       rsp_res_ff;
   logic [63:0]      rsp_key_ff;
   logic [1:0]       rsp_ist_ff;
   logic             rsp_sel_ff, rsp_last_ff;

   // Table lookups, all evaluated in parallel over the entries.
   logic             any_hit, full, any_valid, newest_found, flush_found;
   logic [IDX_W-1:0] hit_idx, free_idx, newest_idx, victim_idx, flush_idx;
   logic [IDX_W-1:0] victim_age;
   logic [7:0]       clamp_sec;
   logic [15:0]      timeout_ms;
   logic             consent_on, active, nominated, higher, accept, do_sel;

   always_comb begin
      any_hit      = 1'b0;
      hit_idx      = '0;
      full         = 1'b1;
      free_idx     = '0;
      any_valid    = 1'b0;
      newest_found = 1'b0;
      newest_idx   = '0;
      victim_idx   = '0;
      flush_found  = 1'b0;
      flush_idx    = '0;
      victim_age   = (sel_ok_ff && age_ff[sel_idx_ff] == AGE_TOP) ? AGE_NEXT : AGE_TOP;
      for (int j = MAX_ENTRIES - 1; j >= 0; j--) begin
         if (valid_ff[j] && key_ff[j] == item_ff.tuple_key) begin
            any_hit = 1'b1;
            hit_idx = IDX_W'(j);
         end
         if (!valid_ff[j]) begin
            full     = 1'b0;
            free_idx = IDX_W'(j);
         end else begin
            any_valid = 1'b1;
         end
         if (valid_ff[j] && age_ff[j] == '0) begin
            newest_found = 1'b1;
            newest_idx   = IDX_W'(j);
         end
         if (age_ff[j] == victim_age && !(sel_ok_ff && sel_idx_ff == IDX_W'(j))) begin
            victim_idx   = IDX_W'(j);
         end
         if (valid_ff[j] && {1'b0, age_ff[j]} == flush_ff) begin
            flush_found = 1'b1;
            flush_idx   = IDX_W'(j);
         end
      end
      if (cfg_ff < ilbst_pkg::CONSENT_MIN_SEC) begin
         clamp_sec = ilbst_pkg::CONSENT_MIN_SEC;
      end else if (cfg_ff > ilbst_pkg::CONSENT_MAX_SEC) begin
         clamp_sec = ilbst_pkg::CONSENT_MAX_SEC;
      end else begin
         clamp_sec = cfg_ff;
      end
      timeout_ms = 16'(clamp_sec[5:0]) * ilbst_pkg::MS_PER_SEC;
      consent_on = (cfg_ff != 8'd0);
      active     = (ist_ff == ilbst_pkg::ICE_CONN) || (ist_ff == ilbst_pkg::ICE_COMP);
      nominated  = item_ff.use_candidate || item_ff.has_nomination;
      higher     = item_ff.has_nomination && (item_ff.nomination > nom_ff);
      accept     = !item_ff.has_nomination || higher;
   end

   always_comb begin
      state_in  = state_ff;
      item_in   = item_ff;
      ist_in    = ist_ff;
      sel_ok_in = sel_ok_ff;
      sel_idx_in = sel_idx_ff;
      nom_in    = nom_ff;
      old_in    = old_ff;
      run_in    = run_ff;
      rem_in    = rem_ff;
      slot_in   = slot_ff;
      vkey_in   = vkey_ff;
      post_in   = post_ff;
      post_v_in = post_v_ff;
      flush_in  = flush_ff;
      valid_in  = valid_ff;
      age_in    = age_ff;
      key_we    = 1'b0;
      key_widx  = '0;
      ev_we     = 1'b0;
      ev_code   = ilbst_pkg::EV_SUCCESS;
      ev_key    = '0;
      q_pop     = 1'b0;
      ev_load   = 1'b0;
      rptr_in   = rptr_ff;
      do_sel    = 1'b0;
      case (state_ff)
         ilbst_pkg::BK_IDLE: begin
            if (q_valid) begin
               q_pop   = 1'b1;
               item_in = q_item;
               case (q_item.func)
                  ilbst_pkg::FUNC_REQUEST: state_in = ilbst_pkg::BK_REQ_CHECK;
                  ilbst_pkg::FUNC_REMOVE:  state_in = ilbst_pkg::BK_RM_FIND;
                  ilbst_pkg::FUNC_FSELECT: state_in = ilbst_pkg::BK_FSEL;
                  ilbst_pkg::FUNC_TICK:    state_in = ilbst_pkg::BK_TICK;
                  ilbst_pkg::FUNC_RESTART: state_in = ilbst_pkg::BK_RESTART;
                  default:                 state_in = ilbst_pkg::BK_DRAIN;
               endcase
            end
         end
         ilbst_pkg::BK_REQ_CHECK: begin
            state_in = ilbst_pkg::BK_DRAIN;
            if (!item_ff.is_binding || !item_ff.has_fingerprint ||
                item_ff.priority_req == 32'd0) begin
               ev_we   = 1'b1;
               ev_code = ilbst_pkg::EV_ERR400;
               ev_key  = item_ff.tuple_key;
            end else begin
               case (item_ff.auth_result)
                  ilbst_pkg::AUTH_OK: begin
                     if (old_ff) begin
                        ev_we   = 1'b1;
                        ev_code = ilbst_pkg::EV_OLD_RETIRED;
                        old_in  = 1'b0;
                     end
                     state_in = ilbst_pkg::BK_REQ_ROLE;
                  end
                  ilbst_pkg::AUTH_UNAUTH: begin
                     if (old_ff && item_ff.old_auth_ok) begin
                        state_in = ilbst_pkg::BK_REQ_ROLE;
                     end else begin
                        ev_we   = 1'b1;
                        ev_code = ilbst_pkg::EV_ERR401;
                        ev_key  = item_ff.tuple_key;
                     end
                  end
                  default: begin
                     ev_we   = 1'b1;
                     ev_code = ilbst_pkg::EV_ERR400;
                     ev_key  = item_ff.tuple_key;
                  end
               endcase
            end
         end
         ilbst_pkg::BK_REQ_ROLE: begin
            ev_we  = 1'b1;
            ev_key = item_ff.tuple_key;
            if (item_ff.ice_controlled) begin
               ev_code  = ilbst_pkg::EV_ERR487;
               state_in = ilbst_pkg::BK_DRAIN;
            end else begin
               ev_code  = ilbst_pkg::EV_SUCCESS;
               state_in = ilbst_pkg::BK_REQ_ADD;
            end
         end
         ilbst_pkg::BK_REQ_ADD: begin
            state_in = ilbst_pkg::BK_REQ_NOM;
            if (any_hit) begin
               slot_in = hit_idx;
            end else begin
               ev_we   = 1'b1;
               ev_code = ilbst_pkg::EV_ADDED;
               ev_key  = item_ff.tuple_key;
               key_we  = 1'b1;
               if (!full) begin
                  for (int j = 0; j < MAX_ENTRIES; j++) begin
                     if (valid_ff[j]) age_in[j] = age_ff[j] + 1'b1;
                  end
                  key_widx = free_idx;
                  valid_in[free_idx] = 1'b1;
                  age_in[free_idx]   = '0;
                  slot_in  = free_idx;
               end else begin
                  // Dropping the victim and ageing the rest only moves entries younger than it.
                  for (int j = 0; j < MAX_ENTRIES; j++) begin
                     if (age_ff[j] < victim_age) age_in[j] = age_ff[j] + 1'b1;
                  end
                  key_widx = victim_idx;
                  age_in[victim_idx] = '0;
                  vkey_in  = key_ff[victim_idx];
                  slot_in  = victim_idx;
                  state_in = ilbst_pkg::BK_REQ_EVICT;
               end
            end
         end
         ilbst_pkg::BK_REQ_EVICT: begin
            ev_we    = 1'b1;
            ev_code  = ilbst_pkg::EV_REMOVED;
            ev_key   = vkey_ff;
            state_in = ilbst_pkg::BK_REQ_NOM;
         end
         ilbst_pkg::BK_REQ_NOM: begin
            post_v_in = 1'b0;
            post_in   = ilbst_pkg::EV_COMPLETED;
            if (!active) begin
               if (!nominated) begin
                  ist_in    = ilbst_pkg::ICE_CONN;
                  do_sel    = 1'b1;
                  post_v_in = 1'b1;
                  post_in   = ilbst_pkg::EV_CONNECTED;
               end else if (accept) begin
                  ist_in    = ilbst_pkg::ICE_COMP;
                  do_sel    = 1'b1;
                  post_v_in = 1'b1;
                  if (higher) nom_in = item_ff.nomination;
               end
            end else if (nominated && accept) begin
               post_v_in = (ist_ff == ilbst_pkg::ICE_CONN);
               ist_in    = ilbst_pkg::ICE_COMP;
               do_sel    = 1'b1;
               if (higher) nom_in = item_ff.nomination;
            end
            if (do_sel && !(sel_ok_ff && sel_idx_ff == slot_ff)) begin
               sel_ok_in  = 1'b1;
               sel_idx_in = slot_ff;
               ev_we      = 1'b1;
               ev_code    = ilbst_pkg::EV_SELECTED;
               ev_key     = item_ff.tuple_key;
            end
            state_in = ilbst_pkg::BK_REQ_POST;
         end
         ilbst_pkg::BK_REQ_POST: begin
            ev_we   = post_v_ff;
            ev_code = post_ff;
            if (consent_on && active) begin
               run_in = 1'b1;
               rem_in = timeout_ms;
            end
            state_in = ilbst_pkg::BK_DRAIN;
         end
         ilbst_pkg::BK_RM_FIND: begin
            state_in = ilbst_pkg::BK_DRAIN;
            if (any_hit) begin
               ev_we   = 1'b1;
               ev_code = ilbst_pkg::EV_REMOVED;
               ev_key  = item_ff.tuple_key;
               valid_in[hit_idx] = 1'b0;
               for (int j = 0; j < MAX_ENTRIES; j++) begin
                  if (valid_ff[j] && age_ff[j] > age_ff[hit_idx]) age_in[j] = age_ff[j] - 1'b1;
               end
               if (sel_ok_ff && sel_idx_ff == hit_idx) state_in = ilbst_pkg::BK_RM_SEL;
            end
         end
         ilbst_pkg::BK_RM_SEL: begin
            ev_we = 1'b1;
            if (active && any_valid && newest_found) begin
               sel_ok_in  = 1'b1;
               sel_idx_in = newest_idx;
               ev_code    = ilbst_pkg::EV_SELECTED;
               ev_key     = key_ff[newest_idx];
               if (consent_on) begin
                  run_in = 1'b1;
                  rem_in = timeout_ms;
               end
            end else begin
               sel_ok_in = 1'b0;
               ist_in    = ilbst_pkg::ICE_DISC;
               nom_in    = '0;
               run_in    = 1'b0;
               ev_code   = ilbst_pkg::EV_DISCONNECTED;
            end
            state_in = ilbst_pkg::BK_DRAIN;
         end
         ilbst_pkg::BK_FSEL: begin
            if (active && any_hit && !(sel_ok_ff && sel_idx_ff == hit_idx)) begin
               sel_ok_in  = 1'b1;
               sel_idx_in = hit_idx;
               ev_we      = 1'b1;
               ev_code    = ilbst_pkg::EV_SELECTED;
               ev_key     = item_ff.tuple_key;
            end
            state_in = ilbst_pkg::BK_DRAIN;
         end
         ilbst_pkg::BK_TICK: begin
            state_in = ilbst_pkg::BK_DRAIN;
            if (run_ff) begin
               if (rem_ff > 16'd1) begin
                  rem_in = rem_ff - 16'd1;
               end else begin
                  rem_in    = '0;
                  run_in    = 1'b0;
                  ist_in    = ilbst_pkg::ICE_DISC;
                  nom_in    = '0;
                  sel_ok_in = 1'b0;
                  flush_in  = '0;
                  state_in  = ilbst_pkg::BK_FLUSH;
               end
            end
         end
         ilbst_pkg::BK_FLUSH: begin
            ev_we = 1'b1;
            // Ages stay packed from zero, so the sweep stops at the first missing age.
            if (flush_ff < FLUSH_END && flush_found) begin
               ev_code  = ilbst_pkg::EV_REMOVED;
               ev_key   = key_ff[flush_idx];
               flush_in = flush_ff + 1'b1;
            end else begin
               for (int j = 0; j < MAX_ENTRIES; j++) begin
                  valid_in[j] = 1'b0;
                  age_in[j]   = '0;
               end
               ev_code  = ilbst_pkg::EV_DISCONNECTED;
               state_in = ilbst_pkg::BK_DRAIN;
            end
         end
         ilbst_pkg::BK_RESTART: begin
            ev_we   = old_ff;
            ev_code = ilbst_pkg::EV_OLD_RETIRED;
            old_in  = 1'b1;
            nom_in  = '0;
            if (consent_on && run_ff) begin
               run_in = 1'b1;
               rem_in = timeout_ms;
            end
            state_in = ilbst_pkg::BK_DRAIN;
         end
         ilbst_pkg::BK_DRAIN: begin
            if (rptr_ff == wptr_ff) begin
               rptr_in  = '0;
               state_in = ilbst_pkg::BK_IDLE;
            end else if (!rsp_valid_ff || !out_stall) begin
               ev_load = 1'b1;
               rptr_in = rptr_ff + 1'b1;
            end
         end
         default: state_in = ilbst_pkg::BK_IDLE;
      endcase
      if (state_ff == ilbst_pkg::BK_DRAIN && rptr_ff == wptr_ff) begin
         wptr_in = '0;
      end else begin
         wptr_in = wptr_ff + EV_CW'(ev_we);
      end
      if (ev_load) begin
         rsp_valid_in = 1'b1;
      end else if (!out_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ilbst_pkg::BK_IDLE;
         ist_ff       <= ilbst_pkg::ICE_NEW;
         sel_ok_ff    <= 1'b0;
         sel_idx_ff   <= '0;
         nom_ff       <= '0;
         old_ff       <= 1'b0;
         run_ff       <= 1'b0;
         rem_ff       <= '0;
         cfg_ff       <= '0;
         wptr_ff      <= '0;
         rptr_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         for (int j = 0; j < MAX_ENTRIES; j++) begin
            valid_ff[j] <= 1'b0;
            age_ff[j]   <= '0;
         end
      end else begin
         state_ff     <= state_in;
         ist_ff       <= ist_in;
         sel_ok_ff    <= sel_ok_in;
         sel_idx_ff   <= sel_idx_in;
         nom_ff       <= nom_in;
         old_ff       <= old_in;
         run_ff       <= run_in;
         rem_ff       <= rem_in;
         if (cfg_we) cfg_ff <= cfg_data;
         wptr_ff      <= wptr_in;
         rptr_ff      <= rptr_in;
         rsp_valid_ff <= rsp_valid_in;
         valid_ff     <= valid_in;
         age_ff       <= age_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff   <= item_in;
      slot_ff   <= slot_in;
      vkey_ff   <= vkey_in;
      post_ff   <= post_in;
      post_v_ff <= post_v_in;
      flush_ff  <= flush_in;
      if (key_we) key_ff[key_widx] <= item_ff.tuple_key;
      if (ev_we) begin
         ev_code_mem[wptr_ff[EV_W-1:0]] <= ev_code;
         ev_key_mem[wptr_ff[EV_W-1:0]]  <= ev_key;
      end
      if (ev_load) begin
         rsp_res_ff  <= ev_code_mem[rptr_ff[EV_W-1:0]];
         rsp_key_ff  <= ev_key_mem[rptr_ff[EV_W-1:0]];
         rsp_ist_ff  <= ist_ff;
         rsp_sel_ff  <= sel_ok_ff;
         rsp_last_ff <= (rptr_ff + 1'b1 == wptr_ff);
      end
   end

   assign out_valid     = rsp_valid_ff;
   assign out_res       = rsp_res_ff;
   assign out_tuple     = rsp_key_ff;
   assign out_ice_state = rsp_ist_ff;
   assign out_sel_valid = rsp_sel_ff;
   assign out_last      = rsp_last_ff;
endmodule

// File: hw/rtl/ice_lite_binding_session_tracker_unit.sv
// Top level of the ICE-lite binding session tracker.
// Input transfers are queued two deep in front of a sequencer that handles one item at a time:
// each item is classified and applied (a valid request that evicts a tuple adds a removal
// event, and a consent expiry sweeps the table), then its result transfers leave one per cycle
// while the output is not stalled, and the sequencer returns to idle. The events of an item are
// buffered and then drained through the output register, so every result carries the session
// state and selection after the whole item. The consent timeout register is sampled when the
// timer is armed.
module ice_lite_binding_session_tracker_unit #(
   parameter int MAX_ENTRIES = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [7:0]  csr_wr_data,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_func,
   input  logic [63:0] req_tuple_key,
   input  logic        req_is_binding,
   input  logic        req_has_fingerprint,
   input  logic [31:0] req_priority_req,
   input  logic [1:0]  req_auth_result,
   input  logic        req_old_auth_ok,
   input  logic        req_ice_controlled,
   input  logic        req_use_candidate,
   input  logic        req_has_nomination,
   input  logic [31:0] req_nomination,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [3:0]  rsp_event_res,
   output logic [63:0] rsp_event_tuple,
   output logic [1:0]  rsp_ice_state_out,
   output logic        rsp_selected_valid,
   output logic        rsp_last
);
   ilbst_pkg::item_type in_item, q_item;
   logic q_valid, q_pop;

   always_comb begin
      in_item.func            = req_func;
      in_item.tuple_key       = req_tuple_key;
      in_item.is_binding      = req_is_binding;
      in_item.has_fingerprint = req_has_fingerprint;
      in_item.priority_req    = req_priority_req;
      in_item.auth_result     = req_auth_result;
      in_item.old_auth_ok     = req_old_auth_ok;
      in_item.ice_controlled  = req_ice_controlled;
      in_item.use_candidate   = req_use_candidate;
      in_item.has_nomination  = req_has_nomination;
      in_item.nomination      = req_nomination;
   end

   ilbst_front u_front (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_valid),
      .in_stall (req_stall),
      .in_item  (in_item),
      .q_valid  (q_valid),
      .q_item   (q_item),
      .q_pop    (q_pop)
   );

   ilbst_back #(.MAX_ENTRIES(MAX_ENTRIES)) u_back (
      .clock         (clock),
      .reset         (reset),
      .cfg_we        (csr_wr_en),
      .cfg_data      (csr_wr_data),
      .q_valid       (q_valid),
      .q_item        (q_item),
      .q_pop         (q_pop),
      .out_valid     (rsp_valid),
      .out_stall     (rsp_stall),
      .out_res       (rsp_event_res),
      .out_tuple     (rsp_event_tuple),
      .out_ice_state (rsp_ice_state_out),
      .out_sel_valid (rsp_selected_valid),
      .out_last      (rsp_last)
   );
endmodule

// File: hw/rtl/ilbst_checker.sv
// Port-level checks for the session tracker, bound to the top level.
module ilbst_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [3:0] rsp_event_res,
   input logic [1:0] rsp_ice_state_out,
   input logic       rsp_selected_valid,
   input logic       rsp_last
);
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_event_res))
      else $error("result transfer dropped while stalled");

   a_connected_state: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_event_res == ilbst_pkg::EV_CONNECTED
         |-> rsp_ice_state_out == ilbst_pkg::ICE_CONN && rsp_selected_valid)
      else $error("connected event without connected state");

   a_selected_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_event_res == ilbst_pkg::EV_SELECTED |-> rsp_selected_valid)
      else $error("selected event without a selection");

   a_disc_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_event_res == ilbst_pkg::EV_DISCONNECTED
         |-> rsp_last && rsp_ice_state_out == ilbst_pkg::ICE_DISC && !rsp_selected_valid)
      else $error("disconnected event is not final");
endmodule

bind ice_lite_binding_session_tracker_unit ilbst_checker u_ilbst_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp_valid),
   .rsp_stall          (rsp_stall),
   .rsp_event_res      (rsp_event_res),
   .rsp_ice_state_out  (rsp_ice_state_out),
   .rsp_selected_valid (rsp_selected_valid),
   .rsp_last           (rsp_last)
);
